// ===== src/stg_pkg.sv =====
// ----------------------------------------------------------------------------
// Sine tone generator package
// Shared constants, key codes, register indexes and the rotation angle table.
// ----------------------------------------------------------------------------
package stg_pkg;

	// Audio sample rate in hertz; one full phase turn is this many counts.
	localparam int SAMPLE_RATE     = 44100;
	localparam int SINE_ITERATIONS = 16;
	localparam int MAX_STAGES      = 20;
	localparam int ROT_STEPS       = (SINE_ITERATIONS < MAX_STAGES) ?
		SINE_ITERATIONS : MAX_STAGES;

	// Field and state widths.
	localparam int PHASE_W  = 16;
	localparam int LEVEL_W  = 15;
	localparam int SAMPLE_W = 16;
	localparam int ANGLE_W  = 32;
	localparam int KEY_W    = 8;
	localparam int IDX_W    = 2;

	// Rotation datapath widths: Q2.30 with guard bits, residual angle signed.
	localparam int CW      = 34;
	localparam int ZW      = 32;
	localparam int ATAN_W  = 30;
	localparam int STEP_W  = 5;
	localparam int PROD_W  = 31;

	localparam int SINE_MAX = 32767;
	localparam int SINE_MIN = -32768;
	localparam int TRUNC_BIAS = 32767;

	localparam logic [PHASE_W-1:0] RATE_C   = PHASE_W'(SAMPLE_RATE);
	localparam logic [LEVEL_W-1:0] FREQ_MAX = LEVEL_W'(SAMPLE_RATE / 2);
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

	// Reset values.
	localparam logic [LEVEL_W-1:0] VOLUME_STEP_RST = LEVEL_W'(1000);
	localparam logic [LEVEL_W-1:0] FREQ_STEP_RST   = LEVEL_W'(50);
	localparam logic [LEVEL_W-1:0] VOLUME_RST      = LEVEL_W'(4000);
	localparam logic [LEVEL_W-1:0] FREQ_RST        = LEVEL_W'(400);

	// Gain-compensated starting x of the rotation (about 0.607 in Q2.30).
	localparam logic signed [CW-1:0] ROT_START = CW'(32'h26DD3B6A);

	// Key codes.
	localparam logic [KEY_W-1:0] KEY_VOL_UP    = 8'h2B;
	localparam logic [KEY_W-1:0] KEY_VOL_DOWN  = 8'h2D;
	localparam logic [KEY_W-1:0] KEY_FREQ_UP   = 8'h70;
	localparam logic [KEY_W-1:0] KEY_FREQ_DOWN = 8'h6F;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_VOLUME_STEP = 2'd0;
	localparam logic [IDX_W-1:0] REG_FREQ_STEP   = 2'd1;

	// Input item kinds.
	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_KEY  = 1'b1;

	// atan(2^-i) in binary-angle units, 2^32 being one full turn.
	localparam logic [ATAN_W-1:0] ATAN_TURNS [MAX_STAGES] = '{
		30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
		30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
		30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
		30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518
	};

endpackage

// ===== src/stg_phase_div.sv =====
// ----------------------------------------------------------------------------
// Phase to angle divider
// Bit-serial long division giving floor(phase * 2^32 / SAMPLE_RATE), one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module stg_phase_div
	import stg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [PHASE_W-1:0] phase,
	output logic               done,
	output logic [ANGLE_W-1:0] angle
);

	logic [PHASE_W-1:0]  rem_q;
	logic [ANGLE_W-1:0]  quo_q;
	logic [STEP_W-1:0]   cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [PHASE_W:0]    rem_dbl;
	logic                qbit;
	logic [PHASE_W-1:0]  rem_next;

	// One restoring step: double the remainder and take out the rate once.
	always_comb begin
		rem_dbl  = {rem_q, 1'b0};
		qbit     = (rem_dbl >= {1'b0, RATE_C});
		rem_next = qbit ? PHASE_W'(rem_dbl - {1'b0, RATE_C}) : rem_q << 1;
	end

	// Since the phase stays below the rate, it is the first remainder.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(ANGLE_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= phase;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[ANGLE_W-2:0], qbit};
		end
	end

	assign done  = done_q;
	assign angle = quo_q;

endmodule

// ===== src/stg_cordic.sv =====
// ----------------------------------------------------------------------------
// Iterative sine rotation
// Rotates the first-quadrant angle one step per cycle, then folds the
// quadrant in and scales the result to a saturated Q1.15 sine.
// ----------------------------------------------------------------------------
module stg_cordic
	import stg_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ANGLE_W-1:0]         angle,
	output logic                       done,
	output logic signed [SAMPLE_W-1:0] sine
);

	logic signed [CW-1:0]       x_q, y_q;
	logic signed [ZW-1:0]       z_q;
	logic [1:0]                 quad_q;
	logic [STEP_W-1:0]          step_q;
	logic                       busy_q;
	logic                       fin_q;
	logic                       done_q;
	logic signed [SAMPLE_W-1:0] sine_q;

	logic signed [CW-1:0]       xs, ys;
	logic signed [ZW-1:0]       atan_ext;
	logic signed [CW:0]         v;
	logic signed [CW:0]         vs;
	logic signed [SAMPLE_W-1:0] sat;

	// Shifted terms of the current step; arithmetic shifts round down.
	always_comb begin
		xs       = x_q >>> step_q;
		ys       = y_q >>> step_q;
		atan_ext = ZW'(ATAN_TURNS[step_q]);
	end

	// Quadrant fold, floor scaling to Q1.15 and saturation.
	always_comb begin
		case (quad_q)
			2'd0:    v = (CW+1)'(y_q);
			2'd1:    v = (CW+1)'(x_q);
			2'd2:    v = -((CW+1)'(y_q));
			default: v = -((CW+1)'(x_q));
		endcase
		vs = v >>> 15;
		if (vs > (CW+1)'(SINE_MAX)) begin
			sat = SAMPLE_W'(SINE_MAX);
		end else if (vs < (CW+1)'(SINE_MIN)) begin
			sat = SAMPLE_W'(SINE_MIN);
		end else begin
			sat = vs[SAMPLE_W-1:0];
		end
	end

	// Step control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(ROT_STEPS - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	// Rotation datapath: turn toward zero residual angle.
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= ROT_START;
			y_q    <= '0;
			z_q    <= ZW'(angle[ATAN_W-1:0]);
			quad_q <= angle[ANGLE_W-1:ANGLE_W-2];
		end else if (busy_q) begin
			if (!z_q[ZW-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_ext;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_ext;
			end
		end
		if (fin_q) begin
			sine_q <= sat;
		end
	end

	assign done = done_q;
	assign sine = sine_q;

endmodule

// ===== src/stg_serial_mult.sv =====
// ----------------------------------------------------------------------------
// Serial volume multiplier
// Shift-and-add product of volume and sine, one volume bit per cycle, then
// division by 2^15 truncated toward zero.
// ----------------------------------------------------------------------------
module stg_serial_mult
	import stg_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [LEVEL_W-1:0]         volume,
	input  logic signed [SAMPLE_W-1:0] sine,
	output logic                       done,
	output logic signed [SAMPLE_W-1:0] sample
);

	logic signed [PROD_W-1:0]   acc_q;
	logic signed [PROD_W-1:0]   mcand_q;
	logic [LEVEL_W-1:0]         mplier_q;
	logic [STEP_W-1:0]          cnt_q;
	logic                       busy_q;
	logic                       fin_q;
	logic                       done_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic signed [PROD_W-1:0]   adj;
	logic signed [PROD_W-1:0]   quot;

	// A negative product gets a bias so the floor shift truncates toward zero.
	always_comb begin
		adj  = acc_q[PROD_W-1] ? acc_q + PROD_W'(TRUNC_BIAS) : acc_q;
		quot = adj >>> 15;
	end

	// Step control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(LEVEL_W - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	// Multiplier shifts right, multiplicand shifts left, accumulate.
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			mcand_q  <= PROD_W'(sine);
			mplier_q <= volume;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= mcand_q <<< 1;
			mplier_q <= mplier_q >> 1;
		end
		if (fin_q) begin
			sample_q <= quot[SAMPLE_W-1:0];
		end
	end

	assign done   = done_q;
	assign sample = sample_q;

endmodule

// ===== src/sine_tone_generator_with_key_control.sv =====
// ----------------------------------------------------------------------------
// Sine tone generator with key control
// Direct digital synthesis oscillator whose volume and pitch follow key bytes.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one request per item: s_tuser is the kind
//   (0 = sample tick, 1 = key byte) and s_tdata the key code. A key byte
//   steps volume ('+', '-') or frequency ('p', 'o') with saturation and
//   leaves the input ready; other bytes are dropped. A sample tick yields one
//   stereo sample on the output stream, the same value on both channels.
//   A sample tick passes through the bit-serial phase divider, then the
//   SINE_ITERATIONS steps of the rotation unit, then the serial multiplier
//   and the handoff registers before its sample reaches m_tvalid.
//   Only one tick is worked on at a time: the input takes nothing more until
//   its sample is loaded, and key bytes are taken at one per cycle while idle.
//   The output register holds a finished sample while the receiver stalls;
//   the next tick still runs and waits for that register before it finishes.
//   Asynchronous reset restores volume 4000, frequency 400, phase 0 and the
//   default step registers, and empties the output register.
//   The configuration port is to be written only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module sine_tone_generator_with_key_control
	import stg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [KEY_W-1:0]   s_tdata,   // [7:0] key_code
	input  logic               s_tuser,   // [0] kind
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [31:0]        m_tdata,   // [15:0] sample_left, [31:16] sample_right
	input  logic               cfg_we,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [LEVEL_W-1:0] cfg_wdata
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_COR,
		ST_MUL,
		ST_HOLD
	} state_t;

	state_t                     state_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;

	logic [PHASE_W-1:0] phase_q;
	logic [LEVEL_W-1:0] volume_q;
	logic [LEVEL_W-1:0] freq_q;
	logic [LEVEL_W-1:0] vol_step_q;
	logic [LEVEL_W-1:0] freq_step_q;

	logic                       in_req;
	logic                       tick_req;
	logic                       key_req;
	logic                       out_free;
	logic                       div_done;
	logic [ANGLE_W-1:0]         angle;
	logic                       cor_done;
	logic signed [SAMPLE_W-1:0] sine;
	logic                       mul_done;
	logic signed [SAMPLE_W-1:0] sample;

	logic [PHASE_W:0]   phase_sum;
	logic [PHASE_W-1:0] phase_next;
	logic [LEVEL_W:0]   vol_sum;
	logic [LEVEL_W:0]   freq_sum;

	assign s_tready = (state_q == ST_IDLE);
	assign in_req   = s_tvalid && s_tready;
	assign tick_req = in_req && (s_tuser == KIND_TICK);
	assign key_req  = in_req && (s_tuser == KIND_KEY);
	assign out_free = !out_valid_q || m_tready;

	// Phase advance modulo the sample rate; the sum stays below twice the rate.
	always_comb begin
		phase_sum  = {1'b0, phase_q} + (PHASE_W+1)'(freq_q);
		phase_next = (phase_sum >= (PHASE_W+1)'(RATE_C)) ?
			PHASE_W'(phase_sum - (PHASE_W+1)'(RATE_C)) : phase_sum[PHASE_W-1:0];
		vol_sum    = {1'b0, volume_q} + {1'b0, vol_step_q};
		freq_sum   = {1'b0, freq_q} + {1'b0, freq_step_q};
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_step_q  <= VOLUME_STEP_RST;
			freq_step_q <= FREQ_STEP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VOLUME_STEP: vol_step_q  <= cfg_wdata;
				REG_FREQ_STEP:   freq_step_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Oscillator state: key adjustments and phase advance on each tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			volume_q <= VOLUME_RST;
			freq_q   <= FREQ_RST;
		end else if (tick_req) begin
			phase_q <= phase_next;
		end else if (key_req) begin
			case (s_tdata)
				KEY_VOL_UP:    volume_q <= vol_sum[LEVEL_W] ? LEVEL_MAX : vol_sum[LEVEL_W-1:0];
				KEY_VOL_DOWN:  volume_q <= (volume_q > vol_step_q) ? volume_q - vol_step_q : '0;
				KEY_FREQ_UP:   freq_q   <= (freq_sum > {1'b0, FREQ_MAX}) ?
					FREQ_MAX : freq_sum[LEVEL_W-1:0];
				KEY_FREQ_DOWN: freq_q   <= (freq_q > freq_step_q) ? freq_q - freq_step_q : '0;
				default: ;
			endcase
		end
	end

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid_q  <= 1'b0;
			out_sample_q <= '0;
		end else begin
			// A finished sample loads the output register once it is free;
			// otherwise a taken sample leaves it empty.
			if ((state_q == ST_HOLD) && out_free) begin
				out_valid_q  <= 1'b1;
				out_sample_q <= sample;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (tick_req) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_COR;
					end
				end
				ST_COR: begin
					if (cor_done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mul_done) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	stg_phase_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (tick_req),
		.phase  (phase_q),
		.done   (div_done),
		.angle  (angle)
	);

	stg_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_done),
		.angle  (angle),
		.done   (cor_done),
		.sine   (sine)
	);

	stg_serial_mult u_mult (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_done),
		.volume (volume_q),
		.sine   (sine),
		.done   (mul_done),
		.sample (sample)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_sample_q, out_sample_q};

endmodule

// ===== src/stg_checker.sv =====
// ----------------------------------------------------------------------------
// Sine tone generator port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module stg_checker
	import stg_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             s_tuser,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [31:0]      m_tdata
);

	// A stalled sample stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output sample changed while stalled");

	// Both channels carry the same sample.
	a_stereo_equal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:0] == m_tdata[31:16])
		else $error("left and right channels differ");

	// A sample tick occupies the datapath, so the next request must wait.
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == KIND_TICK) |=> !s_tready)
		else $error("input ready right after a sample tick");

	// A key byte is handled while the input stays open.
	a_key_fast: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == KIND_KEY) |=> s_tready)
		else $error("input not ready after a key byte");

endmodule

bind sine_tone_generator_with_key_control stg_checker u_stg_checker (.*);
